>>> hw/rtl/mef_pkg.sv
// Shared types and constants for the fixed-point Mandelbrot escape block.
// No dependencies; used by mef_front, mef_core and the top level.
`default_nettype none

package mef_pkg;

  localparam int FX_W     = 16;  // Q5.10 word
  localparam int LIMIT_W  = 8;
  localparam int COLOUR_W = 4;
  localparam int ADDR_W   = 5;   // five registers at 4-byte spacing
  localparam int DATA_W   = 32;

  typedef logic signed [FX_W-1:0] fx_t;
  typedef logic [2:0]             reg_idx_t;

  localparam reg_idx_t REG_REAL_MIN  = 3'd0;
  localparam reg_idx_t REG_IMAG_MIN  = 3'd1;
  localparam reg_idx_t REG_REAL_STEP = 3'd2;
  localparam reg_idx_t REG_IMAG_STEP = 3'd3;
  localparam reg_idx_t REG_LIMIT     = 3'd4;

  typedef struct packed {
    fx_t                real_min;
    fx_t                imag_min;
    fx_t                real_step;
    fx_t                imag_step;
    logic [LIMIT_W-1:0] iteration_limit;
  } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/mef_fifo.sv
// Small first-word-fall-through queue used between front, core and output.
// Depends on nothing but its parameters.
`default_nettype none

module mef_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mef_front.sv
// Front end: takes pixel beats and forms the point c in wrapping Q5.10.
// Depends on mef_pkg; feeds the job queue.
`default_nettype none

module mef_front #(
  parameter int COL_W = 10,
  parameter int ROW_W = 10
) (
  input  wire mef_pkg::cfg_t   cfg_i,
  input  wire logic            push_i,
  input  wire logic [COL_W-1:0] column_i,
  input  wire logic [ROW_W-1:0] row_i,
  output logic                 full_o,
  input  wire logic            q_full_i,
  output logic                 q_push_o,
  output logic [COL_W+ROW_W+2*mef_pkg::FX_W-1:0] q_wdata_o
);

  logic [mef_pkg::FX_W-1:0] prod_re, prod_im;
  mef_pkg::fx_t             c_re, c_im;

  // column * step, kept modulo 2^16
  assign prod_re = mef_pkg::FX_W'(column_i) * $unsigned(cfg_i.real_step);
  assign prod_im = mef_pkg::FX_W'(row_i) * $unsigned(cfg_i.imag_step);
  assign c_re    = mef_pkg::fx_t'($unsigned(cfg_i.real_min) + prod_re);
  assign c_im    = mef_pkg::fx_t'($unsigned(cfg_i.imag_min) + prod_im);

  assign full_o    = q_full_i;
  assign q_push_o  = push_i && !q_full_i;
  assign q_wdata_o = {column_i, row_i, c_re, c_im};

endmodule

`default_nettype wire

>>> hw/rtl/mef_core.sv
// Back end: iterates z = z^2 + c, each pass a MIX then a SQR state, and emits the colour.
// Depends on mef_pkg; pops the job queue and pushes the result queue.
`default_nettype none

module mef_core #(
  parameter int COL_W         = 10,
  parameter int ROW_W         = 10,
  parameter int FRACTION_BITS = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [mef_pkg::LIMIT_W-1:0]   limit_i,
  input  wire logic                          job_valid_i,
  input  wire logic [COL_W+ROW_W+2*mef_pkg::FX_W-1:0] job_data_i,
  output logic                               job_pop_o,
  output logic                               res_valid_o,
  input  wire logic                          res_ready_i,
  output logic [COL_W+ROW_W+mef_pkg::COLOUR_W-1:0] res_data_o
);

  localparam int FX_W = mef_pkg::FX_W;
  // escape threshold 4.0, wrapped to a signed 16-bit word
  localparam mef_pkg::fx_t THRESH = FX_W'(32'd4 << FRACTION_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MIX  = 2'd1;  // check escape, form next z
  localparam logic [1:0] ST_SQR  = 2'd2;  // square the new z

  logic [1:0]                  state_q, state_d;
  logic                        first_q, first_d;
  logic [mef_pkg::LIMIT_W-1:0] cnt_q, cnt_d;
  mef_pkg::fx_t                zr_q, zr_d, zi_q, zi_d, zr2_q, zr2_d, zi2_q, zi2_d;
  mef_pkg::fx_t                cr_q, cr_d, ci_q, ci_d;
  logic [COL_W-1:0]            col_q, col_d;
  logic [ROW_W-1:0]            row_q, row_d;

  mef_pkg::fx_t        dz, tr, ti, sum;
  logic signed [31:0]  prod_x, prod_r, prod_i;
  logic                done;

  assign sum    = zr2_q + zi2_q;
  assign done   = !first_q && ((cnt_q >= limit_i) || (sum >= THRESH));
  assign dz     = {zr_q[FX_W-2:0], 1'b0};
  assign prod_x = dz * zi_q;
  assign prod_r = zr_q * zr_q;
  assign prod_i = zi_q * zi_q;
  assign tr     = zr2_q - zi2_q + cr_q;
  assign ti     = prod_x[FRACTION_BITS +: FX_W] + ci_q;

  assign res_valid_o = (state_q == ST_MIX) && done;
  assign res_data_o  = {col_q, row_q, cnt_q[mef_pkg::COLOUR_W-1:0]};
  assign job_pop_o   = (state_q == ST_IDLE) && job_valid_i;

  always_comb begin
    state_d = state_q;
    first_d = first_q;
    cnt_d   = cnt_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    zr2_d   = zr2_q;
    zi2_d   = zi2_q;
    cr_d    = cr_q;
    ci_d    = ci_q;
    col_d   = col_q;
    row_d   = row_q;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          {col_d, row_d, cr_d, ci_d} = job_data_i;
          zr_d    = '0;
          zi_d    = '0;
          zr2_d   = '0;
          zi2_d   = '0;
          cnt_d   = '0;
          first_d = 1'b1;
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        if (done) begin
          if (res_ready_i) begin
            state_d = ST_IDLE;
          end
        end else begin
          zr_d    = tr;
          zi_d    = ti;
          first_d = 1'b0;
          if (!first_q) begin
            cnt_d = cnt_q + 1'b1;
          end
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        zr2_d   = prod_r[FRACTION_BITS +: FX_W];
        zi2_d   = prod_i[FRACTION_BITS +: FX_W];
        state_d = ST_MIX;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      first_q <= 1'b1;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zr_q  <= zr_d;
    zi_q  <= zi_d;
    zr2_q <= zr2_d;
    zi2_q <= zi2_d;
    cr_q  <= cr_d;
    ci_q  <= ci_d;
    col_q <= col_d;
    row_q <= row_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/mandelbrot_escape_fixed.sv
// Top level of the fixed-point Mandelbrot escape-time block.
// Depends on mef_pkg, mef_front, mef_fifo and mef_core.
`default_nettype none

// Each pixel beat (column, row) yields one result beat (pixel_column, pixel_row,
// colour), in order. The point c = (real_min + column*real_step,
// imag_min + row*imag_step) is formed in signed 16-bit Q5.10 with wraparound,
// and z = z^2 + c is iterated from zero until the pass count passes
// iteration_limit or |z|^2 reaches 4.0; colour is (passes - 1) mod 16.
// Products are floor-shifted by FRACTION_BITS and every sum wraps at 16 bits,
// so large coordinates alias rather than saturate. The front end computes c on
// the accept cycle and drops the job into a two-entry queue; the core runs one
// pixel at a time. Each pass in the core forms the cross product, then the two
// squares. Results wait in a two-entry output queue, so the core moves on while
// the consumer stalls. Configuration registers sit on an APB-style port at byte
// addresses 0x00..0x10 and must only be written while the block is idle; reads
// return signed fields sign-extended to 32 bits.

module mandelbrot_escape_fixed #(
  parameter int MAX_COLUMNS   = 1024,
  parameter int MAX_ROWS      = 1024,
  parameter int FRACTION_BITS = 10
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // pixel input queue
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [$clog2(MAX_COLUMNS)-1:0]  column_i,
  input  wire logic [$clog2(MAX_ROWS)-1:0]     row_i,
  // result queue
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [$clog2(MAX_COLUMNS)-1:0]       pixel_column_o,
  output logic [$clog2(MAX_ROWS)-1:0]          pixel_row_o,
  output logic [mef_pkg::COLOUR_W-1:0]         colour_o,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mef_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [mef_pkg::DATA_W-1:0]      pwdata,
  output logic [mef_pkg::DATA_W-1:0]           prdata,
  output logic                                 pready
);

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int FX_W  = mef_pkg::FX_W;
  localparam int JOB_W = COL_W + ROW_W + 2 * FX_W;
  localparam int RES_W = COL_W + ROW_W + mef_pkg::COLOUR_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  mef_pkg::cfg_t     cfg_q;
  mef_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[mef_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.real_min        <= -16'sd2048;
      cfg_q.imag_min        <= -16'sd1280;
      cfg_q.real_step       <= 16'sd9;
      cfg_q.imag_step       <= 16'sd13;
      cfg_q.iteration_limit <= 8'd16;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        mef_pkg::REG_REAL_MIN:  cfg_q.real_min        <= pwdata[FX_W-1:0];
        mef_pkg::REG_IMAG_MIN:  cfg_q.imag_min        <= pwdata[FX_W-1:0];
        mef_pkg::REG_REAL_STEP: cfg_q.real_step       <= pwdata[FX_W-1:0];
        mef_pkg::REG_IMAG_STEP: cfg_q.imag_step       <= pwdata[FX_W-1:0];
        mef_pkg::REG_LIMIT:     cfg_q.iteration_limit <= pwdata[mef_pkg::LIMIT_W-1:0];
        default: ;  // addresses past the last register are ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mef_pkg::REG_REAL_MIN:  prdata = mef_pkg::DATA_W'(cfg_q.real_min);
      mef_pkg::REG_IMAG_MIN:  prdata = mef_pkg::DATA_W'(cfg_q.imag_min);
      mef_pkg::REG_REAL_STEP: prdata = mef_pkg::DATA_W'(cfg_q.real_step);
      mef_pkg::REG_IMAG_STEP: prdata = mef_pkg::DATA_W'(cfg_q.imag_step);
      mef_pkg::REG_LIMIT:     prdata = mef_pkg::DATA_W'(cfg_q.iteration_limit);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Front end -> job queue -> core -> result queue
  // ---------------------------------------------------------------------------
  logic             job_push, job_full, job_empty, job_pop;
  logic [JOB_W-1:0] job_wdata, job_rdata;
  logic             res_valid, res_full, res_push;
  logic [RES_W-1:0] res_wdata, res_rdata;

  mef_front #(
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_front (
    .cfg_i     (cfg_q),
    .push_i    (push),
    .column_i  (column_i),
    .row_i     (row_i),
    .full_o    (full),
    .q_full_i  (job_full),
    .q_push_o  (job_push),
    .q_wdata_o (job_wdata)
  );

  mef_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (2)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_wdata),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .rdata_o (job_rdata),
    .empty_o (job_empty)
  );

  mef_core #(
    .COL_W         (COL_W),
    .ROW_W         (ROW_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (cfg_q.iteration_limit),
    .job_valid_i (!job_empty),
    .job_data_i  (job_rdata),
    .job_pop_o   (job_pop),
    .res_valid_o (res_valid),
    .res_ready_i (!res_full),
    .res_data_o  (res_wdata)
  );

  assign res_push = res_valid && !res_full;

  mef_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wdata),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign {pixel_column_o, pixel_row_o, colour_o} = res_rdata;

`ifndef SYNTHESIS
  // the core only takes a job that the queue actually holds
  assert property (@(posedge clk_i) disable iff (!rst_ni) job_pop |-> !job_empty)
    else $error("core popped an empty job queue");

  // a finished pixel always lands in the result queue on its beat
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |=> !empty)
    else $error("result beat lost on its way to the output queue");

  // the core holds a finished result while the output queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (res_valid && res_full) |=> res_valid)
    else $error("core dropped a stalled result");
`endif

endmodule

`default_nettype wire

>>> verif/tb_mandelbrot_escape_fixed.sv
// Self-checking testbench for mandelbrot_escape_fixed: directed and random pixel beats,
// with a fixed-point escape-time predictor and in-order result scoreboard.
// Depends on mef_pkg and the mandelbrot_escape_fixed RTL.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_fixed;

  localparam int COL_W     = 10;
  localparam int ROW_W     = 10;
  localparam int FRAC_BITS = 10;
  localparam int FX_W      = mef_pkg::FX_W;
  localparam int LIMIT_W   = mef_pkg::LIMIT_W;
  localparam int COLOUR_W  = mef_pkg::COLOUR_W;
  localparam int ADDR_W    = mef_pkg::ADDR_W;
  localparam int DATA_W    = mef_pkg::DATA_W;

  // |z|^2 escape level, 4.0 in Q5.10, compared as a signed 16-bit value
  localparam mef_pkg::fx_t ESCAPE_LEVEL = mef_pkg::fx_t'(4 << FRAC_BITS);

  localparam int RANDOM_PHASES   = 14;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int PRESSURE_PHASE  = 2;
  localparam int PAUSE_PHASE     = 5;
  localparam int LONG_HOLD       = 300;
  // tail wait covers the longest pixel, up to 256 passes, plus two queues
  localparam int TAIL_CYCLES     = 600;
  localparam int DRAIN_CYCLES    = 4;
  localparam int CYCLE_LIMIT     = 4_000_000;

  typedef struct packed {
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    logic [COLOUR_W-1:0] colour;
  } pixel_result_t;

  // one row of the directed table; new_view reprograms all registers first
  typedef struct packed {
    bit                  new_view;
    mef_pkg::cfg_t       view;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
    bit                  known;
    logic [COLOUR_W-1:0] colour;
  } stim_row_t;

  // register settings: real_min, imag_min, real_step, imag_step, limit
  localparam mef_pkg::cfg_t VIEW_RESET      = '{-16'sd2048, -16'sd1280, 16'sd9, 16'sd13, 8'd16};
  localparam mef_pkg::cfg_t VIEW_ORIGIN     = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd16};
  localparam mef_pkg::cfg_t VIEW_ORIGIN_MAX = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd255};
  localparam mef_pkg::cfg_t VIEW_ORIGIN_TOP = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd254};
  localparam mef_pkg::cfg_t VIEW_NO_PASSES  = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 8'd0};
  localparam mef_pkg::cfg_t VIEW_WRAP       = '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 8'd254};
  localparam mef_pkg::cfg_t VIEW_FAR        = '{16'sd3072, 16'sd0, 16'sd0, 16'sd0, 8'd16};
  localparam mef_pkg::cfg_t VIEW_NEG_ONE    = '{-16'sd1024, 16'sd0, 16'sd0, 16'sd0, 8'd16};
  localparam mef_pkg::cfg_t VIEW_FINE       = '{-16'sd1536, -16'sd512, 16'sd1, 16'sd1, 8'd64};
  localparam mef_pkg::cfg_t VIEW_PRESSURE   = '{-16'sd2048, -16'sd1280, 16'sd3, 16'sd2, 8'd8};

  // Typed colours:
  //   reset corner (-2,-1.25) escapes on the first pass -> 0
  //   c = 0 never escapes, so colour = limit mod 16 (16 -> 0, 255 -> 15, 254 -> 14)
  //   limit of zero always gives one pass -> 0
  //   c = (3.0, 0) gives |z|^2 = 9.0 on the first pass -> 0
  localparam stim_row_t DIRECTED [21] = '{
    '{1'b0, VIEW_RESET,      10'd0,    10'd0,    1'b1, 4'd0},
    '{1'b0, VIEW_RESET,      10'd1023, 10'd1023, 1'b0, 4'd0},
    '{1'b0, VIEW_RESET,      10'h2AA,  10'h155,  1'b0, 4'd0},
    '{1'b0, VIEW_RESET,      10'h155,  10'h2AA,  1'b0, 4'd0},
    '{1'b0, VIEW_RESET,      10'd227,  10'd98,   1'b0, 4'd0},
    '{1'b1, VIEW_ORIGIN,     10'd1023, 10'd0,    1'b1, 4'd0},
    '{1'b1, VIEW_ORIGIN_MAX, 10'd0,    10'd1023, 1'b1, 4'd15},
    '{1'b1, VIEW_ORIGIN_TOP, 10'd5,    10'd5,    1'b1, 4'd14},
    '{1'b1, VIEW_NO_PASSES,  10'd0,    10'd0,    1'b1, 4'd0},
    '{1'b0, VIEW_NO_PASSES,  10'd1023, 10'd1023, 1'b1, 4'd0},
    '{1'b0, VIEW_NO_PASSES,  10'h2AA,  10'h155,  1'b1, 4'd0},
    '{1'b1, VIEW_WRAP,       10'd1,    10'd1,    1'b0, 4'd0},
    '{1'b0, VIEW_WRAP,       10'd1023, 10'd1023, 1'b0, 4'd0},
    '{1'b0, VIEW_WRAP,       10'd2,    10'd3,    1'b0, 4'd0},
    '{1'b0, VIEW_WRAP,       10'd512,  10'd512,  1'b0, 4'd0},
    '{1'b1, VIEW_FAR,        10'd7,    10'd9,    1'b1, 4'd0},
    '{1'b1, VIEW_NEG_ONE,    10'd0,    10'd0,    1'b0, 4'd0},
    '{1'b1, VIEW_FINE,       10'd1023, 10'd1023, 1'b0, 4'd0},
    '{1'b0, VIEW_FINE,       10'd900,  10'd512,  1'b0, 4'd0},
    '{1'b0, VIEW_FINE,       10'd1023, 10'd0,    1'b0, 4'd0},
    '{1'b0, VIEW_FINE,       10'd0,    10'd512,  1'b0, 4'd0}
  };

  // DUT inputs start known; everything after time zero is driven at clock edges
  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                push      = 1'b0;
  logic [COL_W-1:0]    column_i  = '0;
  logic [ROW_W-1:0]    row_i     = '0;
  logic                pop       = 1'b0;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [DATA_W-1:0]   pwdata    = '0;
  logic                full;
  logic                empty;
  logic [COL_W-1:0]    pixel_column_o;
  logic [ROW_W-1:0]    pixel_row_o;
  logic [COLOUR_W-1:0] colour_o;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // predictor's copy of the registers, updated at each write beat
  mef_pkg::cfg_t current_view = VIEW_RESET;
  pixel_result_t pending_pixels [$];

  bit tx_idle_on   = 1'b1;
  bit rx_idle_on   = 1'b1;
  bit hold_request = 1'b0;

  int pixels_sent     = 0;
  int results_checked = 0;
  int fault_count     = 0;
  int settings_used   = 0;
  int deepest_limit   = 16;
  int cycle_count     = 0;

  mandelbrot_escape_fixed dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .column_i       (column_i),
    .row_i          (row_i),
    .empty          (empty),
    .pop            (pop),
    .pixel_column_o (pixel_column_o),
    .pixel_row_o    (pixel_row_o),
    .colour_o       (colour_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // 16x16 signed product, floor shift by the fraction width, low 16 bits kept
  function automatic mef_pkg::fx_t fx_product(mef_pkg::fx_t a, mef_pkg::fx_t b);
    logic signed [31:0] p;
    p = a * b;
    return p[FRAC_BITS+FX_W-1:FRAC_BITS];
  endfunction

  // Escape-time colour of one pixel; every sum wraps at 16 bits.
  function automatic logic [COLOUR_W-1:0] escape_colour(mef_pkg::cfg_t view,
                                                         logic [COL_W-1:0] col,
                                                         logic [ROW_W-1:0] row);
    mef_pkg::fx_t cr, ci, zr, zi, zr2, zi2, tr, ti, sum;
    int unsigned passes;
    bit more;
    cr = view.real_min + mef_pkg::fx_t'(col) * view.real_step;
    ci = view.imag_min + mef_pkg::fx_t'(row) * view.imag_step;
    zr = '0;
    zi = '0;
    zr2 = '0;
    zi2 = '0;
    passes = 0;
    do begin
      tr = zr2 - zi2 + cr;
      ti = fx_product(mef_pkg::fx_t'(zr << 1), zi) + ci;
      zr = tr;
      zi = ti;
      zr2 = fx_product(zr, zr);
      zi2 = fx_product(zi, zi);
      sum = zr2 + zi2;
      more = (passes < view.iteration_limit) && (sum < ESCAPE_LEVEL);
      passes++;
    end while (more);
    return COLOUR_W'(passes - 1);
  endfunction

  // Setup then access cycle; leaves the bus selected so back-to-back writes
  // never assign psel twice in one step. configure() idles the bus afterwards.
  task automatic write_register(mef_pkg::reg_idx_t idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      mef_pkg::REG_REAL_MIN:  current_view.real_min = value[FX_W-1:0];
      mef_pkg::REG_IMAG_MIN:  current_view.imag_min = value[FX_W-1:0];
      mef_pkg::REG_REAL_STEP: current_view.real_step = value[FX_W-1:0];
      mef_pkg::REG_IMAG_STEP: current_view.imag_step = value[FX_W-1:0];
      mef_pkg::REG_LIMIT:     current_view.iteration_limit = value[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(mef_pkg::cfg_t v);
    write_register(mef_pkg::REG_REAL_MIN, 32'(v.real_min));
    write_register(mef_pkg::REG_IMAG_MIN, 32'(v.imag_min));
    write_register(mef_pkg::REG_REAL_STEP, 32'(v.real_step));
    write_register(mef_pkg::REG_IMAG_STEP, 32'(v.imag_step));
    write_register(mef_pkg::REG_LIMIT, 32'(v.iteration_limit));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
    if (int'(v.iteration_limit) > deepest_limit) deepest_limit = v.iteration_limit;
  endtask

  // Offers one pixel beat and returns at the edge that accepts it. push stays
  // high into the next call unless that call draws a gap.
  task automatic send_pixel(logic [COL_W-1:0] col, logic [ROW_W-1:0] row, bit known,
                            logic [COLOUR_W-1:0] colour);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push     <= 1'b1;
    column_i <= col;
    row_i    <= row;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_pixels.push_back(pixel_result_t'{col, row,
                             known ? colour : escape_colour(current_view, col, row)});
    pixels_sent++;
  endtask

  // Stop offering and wait for every outstanding result, then stay quiet as the caller asks.
  task automatic settle(int quiet_cycles);
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (quiet_cycles) @(posedge clk_i);
  endtask

  // Compare one popped result beat against the oldest outstanding pixel.
  task automatic check_pixel();
    pixel_result_t want;
    if (pending_pixels.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("ERROR: result beat with nothing outstanding: col=%0d row=%0d colour=%0d",
                 pixel_column_o, pixel_row_o, colour_o);
    end else begin
      want = pending_pixels.pop_front();
      if (pixel_column_o !== want.col || pixel_row_o !== want.row || colour_o !== want.colour)
      begin
        fault_count++;
        if (fault_count <= 10)
          $display("ERROR: result %0d: expected col=%0d row=%0d colour=%0d, got %0d/%0d/%0d",
                   results_checked, want.col, want.row, want.colour,
                   pixel_column_o, pixel_row_o, colour_o);
      end
      results_checked++;
    end
  endtask

  // Result side: random stall per beat, plus one long hold-off on request.
  initial begin : result_sink
    int idle;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      idle = rx_idle_on ? $urandom_range(0, 11) : 0;
      if (hold_request) begin
        hold_request = 1'b0;
        idle = LONG_HOLD;
      end
      if (idle > 0) begin
        pop <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      check_pixel();
    end
  end

  initial begin : watchdog
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, pending_pixels.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : pixel_source
    mef_pkg::cfg_t view;
    int pick;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: extremes, limit edge cases, wraparound, far and interior points.
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].new_view) begin
        settle(DRAIN_CYCLES);
        configure(DIRECTED[i].view);
      end
      send_pixel(DIRECTED[i].col, DIRECTED[i].row, DIRECTED[i].known, DIRECTED[i].colour);
    end

    // Random phases: each drains, reprograms every register, then streams pixels.
    col = '0;
    row = '0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle(DRAIN_CYCLES);
      if (phase % 4 == 3) begin
        // arbitrary 16-bit corners and steps: mostly wraparound territory
        view.real_min  = mef_pkg::fx_t'($urandom);
        view.imag_min  = mef_pkg::fx_t'($urandom);
        view.real_step = mef_pkg::fx_t'($urandom);
        view.imag_step = mef_pkg::fx_t'($urandom);
      end else begin
        // a window over the set, sized so 1024 pixels span a few units
        view.real_min  = mef_pkg::fx_t'(-2560 + int'($urandom_range(0, 2048)));
        view.imag_min  = mef_pkg::fx_t'(-1536 + int'($urandom_range(0, 1536)));
        view.real_step = mef_pkg::fx_t'($urandom_range(1, 6));
        view.imag_step = mef_pkg::fx_t'($urandom_range(1, 6));
        if ($urandom_range(0, 3) == 0) view.real_step = -view.real_step;
        if ($urandom_range(0, 3) == 0) view.imag_step = -view.imag_step;
      end
      // keep deep limits rare: an interior pixel at 255 holds the core for all 256 passes
      pick = $urandom_range(0, 9);
      if (pick < 7)      view.iteration_limit = LIMIT_W'($urandom_range(0, 40));
      else if (pick < 9) view.iteration_limit = LIMIT_W'($urandom_range(41, 120));
      else               view.iteration_limit = LIMIT_W'($urandom_range(200, 255));
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (phase == PRESSURE_PHASE) begin
        // short limit, sender flat out, sink holds off: both queues fill, full rises
        view = VIEW_PRESSURE;
        tx_idle_on = 1'b0;
        hold_request = 1'b1;
      end
      configure(view);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // half the beats walk along a raster line, the rest jump anywhere
        if ($urandom_range(0, 1) == 1) begin
          col = col + 1'b1;
        end else begin
          col = COL_W'($urandom);
          row = ROW_W'($urandom);
        end
        if (phase == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2) settle(DRAIN_CYCLES);
        send_pixel(col, row, 1'b0, '0);
      end
    end

    settle(TAIL_CYCLES);
    $display("Run: %0d pixel beats sent, %0d result beats checked, %0d mismatches",
             pixels_sent, results_checked, fault_count);
    $display("Covered %0d register settings, iteration limits 0 to %0d, long sink stall",
             settings_used, deepest_limit);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
